FILE: hdl/wuf_pkg.sv
// Shared types, control-word layout and microprogram for the union-find unit.
package wuf_pkg;

    localparam int NODE_W  = 10;
    localparam int TOTAL_W = 11;
    localparam int STEP_W  = 4;

    typedef struct packed {
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } pair_t;

    typedef struct packed {
        logic               already_joined;
        logic [TOTAL_W-1:0] component_total;
    } result_t;

    // Step addresses of the microprogram.
    localparam logic [STEP_W-1:0] STEP_CLEAR    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_WAIT     = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CHECK    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_WALK_A   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_START_B  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_WALK_B   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_COMPARE  = 4'd6;
    localparam logic [STEP_W-1:0] STEP_FETCH_WB = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LINK     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FINISH   = 4'd9;

    // Jump conditions.
    localparam logic [2:0] COND_NEVER     = 3'd0;
    localparam logic [2:0] COND_ALWAYS    = 3'd1;
    localparam logic [2:0] COND_CLR_DONE  = 3'd2;
    localparam logic [2:0] COND_IN_XFER   = 3'd3;
    localparam logic [2:0] COND_BAD_NODE  = 3'd4;
    localparam logic [2:0] COND_AT_ROOT   = 3'd5;
    localparam logic [2:0] COND_SAME_ROOT = 3'd6;
    localparam logic [2:0] COND_OUT_FREE  = 3'd7;

    // Root walk selection.
    localparam logic [1:0] WALK_NONE = 2'd0;
    localparam logic [1:0] WALK_A    = 2'd1;
    localparam logic [1:0] WALK_B    = 2'd2;

    typedef struct packed {
        logic              take;     // accept a pair in this step
        logic              clear;    // write reset contents at the sweep address
        logic              rd_link;  // read parent at the link just fetched
        logic [1:0]        walk;     // follow links for node a or node b
        logic              wt_rb;    // weight read address is root b, else root a
        logic              ld_wa;    // capture weight of root a
        logic              judge;    // record whether the roots match
        logic              link;     // join the two trees
        logic              finish;   // load the result register
        logic [2:0]        cond;
        logic              loop;     // without a jump, stay on this step
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic clr_done;
        logic in_xfer;
        logic bad_node;
        logic at_root;
        logic same_root;
        logic out_free;
    } cond_flags_t;

    function automatic ucode_t wuf_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = '0;
        unique case (step)
            STEP_CLEAR: begin
                uc.clear  = 1'b1;
                uc.cond   = COND_CLR_DONE;
                uc.loop   = 1'b1;
                uc.target = STEP_WAIT;
            end
            STEP_WAIT: begin
                uc.take   = 1'b1;
                uc.cond   = COND_IN_XFER;
                uc.loop   = 1'b1;
                uc.target = STEP_CHECK;
            end
            STEP_CHECK: begin
                uc.cond   = COND_BAD_NODE;
                uc.target = STEP_FINISH;
            end
            STEP_WALK_A: begin
                uc.walk    = WALK_A;
                uc.rd_link = 1'b1;
                uc.cond    = COND_AT_ROOT;
                uc.loop    = 1'b1;
                uc.target  = STEP_START_B;
            end
            STEP_START_B: begin
                uc.cond   = COND_NEVER;
            end
            STEP_WALK_B: begin
                uc.walk    = WALK_B;
                uc.rd_link = 1'b1;
                uc.cond    = COND_AT_ROOT;
                uc.loop    = 1'b1;
                uc.target  = STEP_COMPARE;
            end
            STEP_COMPARE: begin
                uc.judge  = 1'b1;
                uc.cond   = COND_SAME_ROOT;
                uc.target = STEP_FINISH;
            end
            STEP_FETCH_WB: begin
                uc.ld_wa  = 1'b1;
                uc.wt_rb  = 1'b1;
                uc.cond   = COND_NEVER;
            end
            STEP_LINK: begin
                uc.link   = 1'b1;
                uc.cond   = COND_ALWAYS;
                uc.target = STEP_FINISH;
            end
            STEP_FINISH: begin
                uc.finish = 1'b1;
                uc.cond   = COND_OUT_FREE;
                uc.loop   = 1'b1;
                uc.target = STEP_WAIT;
            end
            default: begin
                uc.cond   = COND_ALWAYS;
                uc.target = STEP_WAIT;
            end
        endcase
        return uc;
    endfunction

endpackage

FILE: hdl/weighted_union_find_unit.sv
// Each pair is range-checked (an out-of-range node goes straight to the finish step), then node
// a and node b are walked to their roots, and the two trees are linked if the roots differ.
// One pair is handled at a time: a new pair is taken only after the last result is loaded. The
// parent memory's single read port follows one link per cycle; a stalled result waits in its register.
// Reset: step counter and result valid clear and the count loads NODE_COUNT at once; then a
// sweep over all NODE_COUNT addresses rewrites both memories while pair_stall stays high.
module weighted_union_find_unit #(
    parameter int NODE_COUNT = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pair_valid,
    output logic            pair_stall,
    input  wuf_pkg::pair_t  pair,
    output logic            result_valid,
    input  logic            result_stall,
    output wuf_pkg::result_t result
);
    import wuf_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int WT_W  = $clog2(NODE_COUNT + 1);

    ucode_t      ctrl;
    cond_flags_t flags;

    logic [IDX_W-1:0] parent_mem [NODE_COUNT];
    logic [WT_W-1:0]  weight_mem [NODE_COUNT];

    logic [IDX_W-1:0]  parent_rd_reg;
    logic [WT_W-1:0]   weight_rd_reg;
    logic [NODE_W-1:0] a_reg;
    logic [NODE_W-1:0] b_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  ra_reg;
    logic [IDX_W-1:0]  rb_reg;
    logic [WT_W-1:0]   wa_reg;
    logic              joined_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic [WT_W-1:0]   count_reg;
    logic              result_valid_reg;
    result_t           result_reg;

    logic             in_xfer;
    logic             out_free;
    logic             a_lighter;
    logic             parent_we;
    logic [IDX_W-1:0] parent_raddr;
    logic [IDX_W-1:0] parent_waddr;
    logic [IDX_W-1:0] parent_wdata;
    logic             weight_we;
    logic [WT_W-1:0]  weight_wdata;
    logic [IDX_W-1:0] weight_raddr;
    logic [IDX_W-1:0] weight_waddr;

    wuf_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign pair_stall   = !ctrl.take;
    assign in_xfer      = pair_valid && !pair_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        flags.clr_done  = (clr_reg == IDX_W'(NODE_COUNT - 1));
        flags.in_xfer   = in_xfer;
        flags.bad_node  = !((32'(a_reg) < NODE_COUNT) && (32'(b_reg) < NODE_COUNT));
        flags.at_root   = (parent_rd_reg == cur_reg);
        flags.same_root = (ra_reg == rb_reg);
        flags.out_free  = out_free;
    end

    // In the link step the weight read register holds the weight of root b.
    assign a_lighter = (wa_reg < weight_rd_reg);

    always_comb
    begin
        parent_raddr = ctrl.rd_link ? parent_rd_reg : cur_reg;
        weight_raddr = ctrl.wt_rb ? rb_reg : ra_reg;
        parent_we    = ctrl.clear || ctrl.link;
        weight_we    = ctrl.clear || ctrl.link;
        if (ctrl.clear)
        begin
            parent_waddr = clr_reg;
            parent_wdata = clr_reg;
            weight_waddr = clr_reg;
            weight_wdata = WT_W'(1);
        end
        else
        begin
            parent_waddr = a_lighter ? ra_reg : rb_reg;
            parent_wdata = a_lighter ? rb_reg : ra_reg;
            weight_waddr = a_lighter ? rb_reg : ra_reg;
            weight_wdata = wa_reg + weight_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (parent_we)
        begin
            parent_mem[parent_waddr] <= parent_wdata;
        end
        parent_rd_reg <= parent_mem[parent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (weight_we)
        begin
            weight_mem[weight_waddr] <= weight_wdata;
        end
        weight_rd_reg <= weight_mem[weight_raddr];
    end

    // Datapath registers; the walk keeps cur_reg equal to the address just read.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_reg      <= pair.node_a;
            b_reg      <= pair.node_b;
            cur_reg    <= IDX_W'(pair.node_a);
            joined_reg <= 1'b0;
        end
        unique case (ctrl.walk)
            WALK_A:
            begin
                if (flags.at_root)
                begin
                    ra_reg  <= cur_reg;
                    cur_reg <= IDX_W'(b_reg);
                end
                else
                begin
                    cur_reg <= parent_rd_reg;
                end
            end
            WALK_B:
            begin
                if (flags.at_root)
                begin
                    rb_reg <= cur_reg;
                end
                else
                begin
                    cur_reg <= parent_rd_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (ctrl.judge)
        begin
            joined_reg <= flags.same_root;
        end
        if (ctrl.ld_wa)
        begin
            wa_reg <= weight_rd_reg;
        end
        if (ctrl.finish && out_free)
        begin
            result_reg.already_joined  <= joined_reg;
            result_reg.component_total <= TOTAL_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg          <= '0;
            count_reg        <= WT_W'(NODE_COUNT);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctrl.link && (count_reg != '0))
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (ctrl.finish && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(ctrl.finish))
        else $error("result appeared without a finish step");

    a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |-> pair_stall)
        else $error("pair transfer possible during the clearing sweep");

    a_count_never_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.link |=> (count_reg <= $past(count_reg)))
        else $error("component count grew");

    a_link_distinct_roots: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.link |-> (ra_reg != rb_reg))
        else $error("tree linked under itself");

endmodule

FILE: hdl/wuf_sequencer.sv
// Step counter, control store and jump logic of the union-find microprogram.
module wuf_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wuf_pkg::cond_flags_t flags,
    output wuf_pkg::ucode_t      ctrl
);
    import wuf_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              jump;

    assign ctrl = wuf_rom(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_CLR_DONE:  jump = flags.clr_done;
            COND_IN_XFER:   jump = flags.in_xfer;
            COND_BAD_NODE:  jump = flags.bad_node;
            COND_AT_ROOT:   jump = flags.at_root;
            COND_SAME_ROOT: jump = flags.same_root;
            COND_OUT_FREE:  jump = flags.out_free;
            default:        jump = 1'b0;
        endcase

        if (jump)
        begin
            step_next = ctrl.target;
        end
        else if (ctrl.loop)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
